// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define CAU_CHECK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define CAU_CHECK_RST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FIELD_W       = 32;
  localparam int KIND_W        = 3;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_WORD_BITS = 32;
  localparam int EPS_INV       = 100000;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PROD_W        = 64;
  localparam int WIDE_W        = 66;
  localparam int ROOT_W        = 32;

  // Operation codes as they arrive on the bus
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAG = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MAG,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [FIELD_W-1:0] a_re;
    logic signed [FIELD_W-1:0] a_im;
    logic signed [FIELD_W-1:0] b_re;
    logic signed [FIELD_W-1:0] b_im;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] re;
    logic [FIELD_W-1:0] im;
    logic               err;
    logic               sat;
  } res_t;

  // Request handshake between stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== src/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Input stage: takes requests, decodes the operation kind, registers them.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [FIELD_W-1:0] in_a_re,
  input  logic signed [FIELD_W-1:0] in_a_im,
  input  logic signed [FIELD_W-1:0] in_b_re,
  input  logic signed [FIELD_W-1:0] in_b_im,
  output hs_t                       fwd_hs_o,
  input  logic                      fwd_ready,
  output item_t                     fwd_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  // Kind decode; unused codes produce an all-zero result
  always_comb begin
    item_nxt.a_re = in_a_re;
    item_nxt.a_im = in_a_im;
    item_nxt.b_re = in_b_re;
    item_nxt.b_im = in_b_im;
    unique case (in_kind)
      KIND_ADD: item_nxt.op = OP_ADD;
      KIND_SUB: item_nxt.op = OP_SUB;
      KIND_MUL: item_nxt.op = OP_MUL;
      KIND_DIV: item_nxt.op = OP_DIV;
      KIND_MAG: item_nxt.op = OP_MAG;
      default:  item_nxt.op = OP_NONE;
    endcase
  end

  assign in_ready       = !valid_r || fwd_ready;
  assign fwd_hs_o.valid = valid_r;
  assign fwd_hs_o.ready = in_ready;
  assign fwd_item       = item_r;

  // Holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== src/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// Small flop FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module cau_queue
  import cau_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign push_ready = (cnt_r != (AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, pipelined restoring divider and square
// root, final clamp, and a two-entry output buffer.
// ----------------------------------------------------------------------------
module cau_back
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int QW = WORD_BITS + 1;
  localparam int NS = (QW > ROOT_W) ? QW : ROOT_W;
  localparam int NW = PROD_W + FRAC_BITS;

  // Smallest denominator accepted: ceil(2^(2F) / 100000)
  localparam logic [PROD_W-1:0] DEN_MIN =
    ((64'd1 << (2*FRAC_BITS)) + 64'(EPS_INV - 1)) / 64'(EPS_INV);

  localparam logic signed [WIDE_W-1:0] MAXP =
    {{(WIDE_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] MINN =
    {{(WIDE_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic              neg;
    logic              over;
    logic [PROD_W-1:0] rem;
    logic [QW-1:0]     low;
    logic [QW-1:0]     q;
  } dlane_t;

  typedef struct packed {
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } slane_t;

  typedef struct packed {
    op_t                op;
    logic               err;
    logic [FIELD_W-1:0] f_re;
    logic [FIELD_W-1:0] f_im;
    logic               f_sat;
    logic [PROD_W-1:0]  ss;
    dlane_t             dr;
    dlane_t             di;
    slane_t             sq;
  } stg_t;

  // Clamp to the word range; returns {flag, value}
  function automatic logic [FIELD_W:0] clamp_w(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    logic                     s;
    if (v > MAXP) begin
      c = MAXP;
      s = 1'b1;
    end else if (v < MINN) begin
      c = MINN;
      s = 1'b1;
    end else begin
      c = v;
      s = 1'b0;
    end
    return {s, c[FIELD_W-1:0]};
  endfunction

  // Divider setup: magnitude, overflow test, initial partial remainder
  function automatic dlane_t dprep(input logic signed [WIDE_W-1:0] num,
                                   input logic [PROD_W-1:0] den);
    dlane_t                   d;
    logic signed [WIDE_W-1:0] m;
    logic [NW-1:0]            nfull;
    logic [NW-1:0]            hi;
    d.neg = num[WIDE_W-1];
    m     = d.neg ? -num : num;
    nfull = {m[PROD_W-1:0], {FRAC_BITS{1'b0}}};
    hi    = nfull >> QW;
    d.over = (hi >= NW'(den));
    d.rem  = hi[PROD_W-1:0];
    d.low  = nfull[QW-1:0];
    d.q    = '0;
    return d;
  endfunction

  // Divider result to signed word
  function automatic logic [FIELD_W:0] dfin(input dlane_t d);
    logic signed [WIDE_W-1:0] v;
    logic signed [WIDE_W-1:0] lim;
    logic [FIELD_W:0]         r;
    v   = WIDE_W'(d.q);
    v   = d.neg ? -v : v;
    lim = d.neg ? MINN : MAXP;
    if (d.over) begin
      r = {1'b1, lim[FIELD_W-1:0]};
    end else begin
      r = clamp_w(v);
    end
    return r;
  endfunction

  logic ce;

  // Stage 1: products and plain sums
  logic                     p1_v_r;
  op_t                      p1_op_r;
  logic signed [PROD_W-1:0] p1_ac_r, p1_bd_r, p1_ad_r, p1_bc_r, p1_xx_r, p1_yy_r;
  logic signed [WIDE_W-1:0] p1_sre_r, p1_sim_r;
  logic signed [FIELD_W-1:0] x_op, y_op;

  assign x_op = (in_item.op == OP_MAG) ? in_item.a_re : in_item.b_re;
  assign y_op = (in_item.op == OP_MAG) ? in_item.a_im : in_item.b_im;

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_op_r <= in_item.op;
      p1_ac_r <= in_item.a_re * in_item.b_re;
      p1_bd_r <= in_item.a_im * in_item.b_im;
      p1_ad_r <= in_item.a_re * in_item.b_im;
      p1_bc_r <= in_item.a_im * in_item.b_re;
      p1_xx_r <= x_op * x_op;
      p1_yy_r <= y_op * y_op;
      if (in_item.op == OP_SUB) begin
        p1_sre_r <= WIDE_W'(in_item.a_re) - WIDE_W'(in_item.b_re);
        p1_sim_r <= WIDE_W'(in_item.a_im) - WIDE_W'(in_item.b_im);
      end else begin
        p1_sre_r <= WIDE_W'(in_item.a_re) + WIDE_W'(in_item.b_re);
        p1_sim_r <= WIDE_W'(in_item.a_im) + WIDE_W'(in_item.b_im);
      end
    end
  end

  // Stage 2: sums of products, add/sub/mul results, near-zero test
  logic                     p2_v_r;
  op_t                      p2_op_r;
  logic [FIELD_W-1:0]       p2_fre_r, p2_fim_r;
  logic                     p2_fsat_r;
  logic signed [WIDE_W-1:0] p2_nre_r, p2_nim_r;
  logic [PROD_W-1:0]        p2_ss_r;
  logic                     p2_err_r;

  logic signed [WIDE_W-1:0] mre, mim, mre_s, mim_s;
  logic [FIELD_W:0]         c_re, c_im;
  logic [PROD_W-1:0]        ss_nxt;

  always_comb begin
    mre   = WIDE_W'(p1_ac_r) - WIDE_W'(p1_bd_r);
    mim   = WIDE_W'(p1_ad_r) + WIDE_W'(p1_bc_r);
    mre_s = mre >>> FRAC_BITS;
    mim_s = mim >>> FRAC_BITS;
    if (p1_op_r == OP_MUL) begin
      c_re = clamp_w(mre_s);
      c_im = clamp_w(mim_s);
    end else begin
      c_re = clamp_w(p1_sre_r);
      c_im = clamp_w(p1_sim_r);
    end
    ss_nxt = $unsigned(p1_xx_r) + $unsigned(p1_yy_r);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_op_r   <= p1_op_r;
      p2_fre_r  <= c_re[FIELD_W-1:0];
      p2_fim_r  <= c_im[FIELD_W-1:0];
      p2_fsat_r <= c_re[FIELD_W] | c_im[FIELD_W];
      p2_nre_r  <= WIDE_W'(p1_ac_r) + WIDE_W'(p1_bd_r);
      p2_nim_r  <= WIDE_W'(p1_bc_r) - WIDE_W'(p1_ad_r);
      p2_ss_r   <= ss_nxt;
      p2_err_r  <= (p1_op_r == OP_DIV) && (ss_nxt < DEN_MIN);
    end
  end

  // Stage 3: lane setup, then one quotient bit / root digit per stage
  logic v_r [NS+1];
  stg_t st_r [NS+1];
  stg_t st_nxt [NS+1];

  always_comb begin
    st_nxt[0].op    = p2_op_r;
    st_nxt[0].err   = p2_err_r;
    st_nxt[0].f_re  = p2_fre_r;
    st_nxt[0].f_im  = p2_fim_r;
    st_nxt[0].f_sat = p2_fsat_r;
    st_nxt[0].ss    = p2_ss_r;
    st_nxt[0].dr    = dprep(p2_nre_r, p2_ss_r);
    st_nxt[0].di    = dprep(p2_nim_r, p2_ss_r);
    st_nxt[0].sq    = '0;
  end

  for (genvar j = 0; j < NS; j++) begin : g_iter
    // bit positions stay in range on stages where a lane is idle
    localparam int BP = (j < QW) ? QW - 1 - j : 0;
    localparam int SP = (j < ROOT_W) ? 2 * (ROOT_W - 1 - j) : 0;

    always_comb begin
      logic [PROD_W:0]   sh_r, sh_i, dd;
      logic [ROOT_W+3:0] sh_s, tr;
      st_nxt[j+1] = st_r[j];
      dd = {1'b0, st_r[j].ss};
      sh_r = '0;
      sh_i = '0;
      sh_s = '0;
      tr   = '0;
      if (j < QW) begin
        // restoring division step, both lanes
        sh_r = {st_r[j].dr.rem, st_r[j].dr.low[BP]};
        if (sh_r >= dd) begin
          sh_r = sh_r - dd;
          st_nxt[j+1].dr.q[BP] = 1'b1;
        end
        st_nxt[j+1].dr.rem = sh_r[PROD_W-1:0];
        sh_i = {st_r[j].di.rem, st_r[j].di.low[BP]};
        if (sh_i >= dd) begin
          sh_i = sh_i - dd;
          st_nxt[j+1].di.q[BP] = 1'b1;
        end
        st_nxt[j+1].di.rem = sh_i[PROD_W-1:0];
      end
      if (j < ROOT_W) begin
        // square root digit
        sh_s = {st_r[j].sq.rem, st_r[j].ss[SP+1:SP]};
        tr   = {2'b00, st_r[j].sq.root, 2'b01};
        if (sh_s >= tr) begin
          sh_s = sh_s - tr;
          st_nxt[j+1].sq.root = {st_r[j].sq.root[ROOT_W-2:0], 1'b1};
        end else begin
          st_nxt[j+1].sq.root = {st_r[j].sq.root[ROOT_W-2:0], 1'b0};
        end
        st_nxt[j+1].sq.rem = sh_s[ROOT_W+1:0];
      end
    end
  end

  for (genvar k = 0; k <= NS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // Valid bits for all pipeline stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (ce) begin
      p1_v_r <= in_valid;
      p2_v_r <= p1_v_r;
      v_r[0] <= p2_v_r;
      for (int k = 0; k < NS; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Final selection
  res_t             fin;
  logic [FIELD_W:0] q_re, q_im, m_re;

  always_comb begin
    q_re = dfin(st_r[NS].dr);
    q_im = dfin(st_r[NS].di);
    m_re = clamp_w(WIDE_W'(st_r[NS].sq.root));
    fin  = '0;
    case (st_r[NS].op) inside
      OP_ADD, OP_SUB, OP_MUL: begin
        fin.re  = st_r[NS].f_re;
        fin.im  = st_r[NS].f_im;
        fin.sat = st_r[NS].f_sat;
      end
      OP_DIV: begin
        if (st_r[NS].err) begin
          fin.err = 1'b1;
        end else begin
          fin.re  = q_re[FIELD_W-1:0];
          fin.im  = q_im[FIELD_W-1:0];
          fin.sat = q_re[FIELD_W] | q_im[FIELD_W];
        end
      end
      OP_MAG: begin
        fin.re  = m_re[FIELD_W-1:0];
        fin.sat = m_re[FIELD_W];
      end
      default: fin = '0;
    endcase
  end

  // Two-entry output buffer; pipeline advances while it has room
  res_t       ob_mem_r [2];
  logic       ob_wr_r;
  logic       ob_rd_r;
  logic [1:0] ob_cnt_r;
  logic       ob_push;
  logic       ob_pop;

  assign ce        = (ob_cnt_r != 2'd2);
  assign in_ready  = ce;
  assign ob_push   = ce && v_r[NS];
  assign out_valid = (ob_cnt_r != 2'd0);
  assign ob_pop    = out_valid && out_ready;
  assign out_res   = ob_mem_r[ob_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= ~ob_rd_r;
      end
      if (ob_push && !ob_pop) begin
        ob_cnt_r <= ob_cnt_r + 2'd1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_r <= ob_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_mem_r[ob_wr_r] <= fin;
    end
  end

endmodule

// ===== src/complex_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add / subtract / multiply / divide / magnitude in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one request per cycle while results are being taken, and returns
// one result per request, in order. From acceptance to the result being
// offered, a request passes the input register, the queue, products, sums,
// setup, then max(WORD_BITS + 1, 32) stages of the restoring divider and
// square root, and the output buffer. Every operation runs the full
// pipeline so results keep request order. The queue and output buffer
// absorb stalls on either side without losing throughput.
module complex_arithmetic_unit_core
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int WORD_BITS = DEF_WORD_BITS
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_real, a_imag, b_real, b_imag
  input  logic [2:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // result_real, result_imag
  output logic [1:0]   out_tuser   // error_code, saturated
);

  hs_t   fwd_hs;
  item_t fwd_item;
  logic  q_ready;
  logic  q_valid;
  item_t q_item;
  logic  back_ready;
  res_t  res;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_a_re   (in_tdata[31:0]),
    .in_a_im   (in_tdata[63:32]),
    .in_b_re   (in_tdata[95:64]),
    .in_b_im   (in_tdata[127:96]),
    .fwd_hs_o  (fwd_hs),
    .fwd_ready (q_ready),
    .fwd_item  (fwd_item)
  );

  cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fwd_hs.valid),
    .push_ready (q_ready),
    .push_item  (fwd_item),
    .pop_valid  (q_valid),
    .pop_ready  (back_ready),
    .pop_item   (q_item)
  );

  cau_back #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (back_ready),
    .in_item   (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.im, res.re};
  assign out_tuser = {res.sat, res.err};

endmodule

// ===== src/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result stays offered
  `CAU_CHECK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  // and unchanged
  `CAU_CHECK(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  // Divide error carries zero parts and no clamp flag
  `CAU_CHECK(a_err_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == 64'd0 && !out_tuser[1], "error result not zero")
  // Nothing offered right after reset
  `CAU_CHECK_RST(a_rst_idle, clk, !rst_n |=> !out_tvalid, "result offered after reset")

endmodule

bind complex_arithmetic_unit_core cau_port_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
